// File: src/sorted_linked_priority_list_top_macros.svh
// ----------------------------------------------------------------------------
// Sorted linked priority list: assertion macros
// Shared concurrent check forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_LINKED_PRIORITY_LIST_TOP_MACROS_SVH
`define SORTED_LINKED_PRIORITY_LIST_TOP_MACROS_SVH

// same-cycle implication
`define SLPL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLPL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/slpl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted linked priority list: package
// Operation codes, controller states and shared structs.
// ----------------------------------------------------------------------------
package slpl_pkg;

    localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
    localparam logic [1:0] KIND_SORTED     = 2'd2;
    localparam logic [1:0] KIND_POP        = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_HKEY,
        S_TKEY,
        S_WALK,
        S_LINK1,
        S_LINK2,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        MODE_FRONT,
        MODE_BACK,
        MODE_MID
    } mode_t;

    typedef struct packed {
        logic       status;
        logic [7:0] popped_index;
    } res_t;

    typedef struct packed {
        logic link_we;
        logic key_we;
    } mem_we_t;

endpackage

// File: src/slpl_node_mem.sv
// ----------------------------------------------------------------------------
// Sorted linked priority list: node pool
// Link and key arrays, one write port each, shared registered read port.
// ----------------------------------------------------------------------------
module slpl_node_mem #(
    parameter int NODES    = 256,
    parameter int KEY_BITS = 32,
    parameter int PW       = 9,
    parameter int IW       = 8
) (
    input  logic                       aclk,
    input  slpl_pkg::mem_we_t          we,
    input  logic [IW-1:0]              link_waddr,
    input  logic [PW-1:0]              link_wdata,
    input  logic [IW-1:0]              key_waddr,
    input  logic signed [KEY_BITS-1:0] key_wdata,
    input  logic [IW-1:0]              rd_addr,
    output logic [PW-1:0]              rd_link,
    output logic signed [KEY_BITS-1:0] rd_key
);
    import slpl_pkg::*;

    logic [PW-1:0]              link_mem [NODES];
    logic signed [KEY_BITS-1:0] key_mem  [NODES];
    logic [PW-1:0]              rd_link_reg;
    logic signed [KEY_BITS-1:0] rd_key_reg;

    always_ff @(posedge aclk) begin
        if (we.link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        rd_link_reg <= link_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (we.key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        rd_key_reg <= key_mem[rd_addr];
    end

    assign rd_link = rd_link_reg;
    assign rd_key  = rd_key_reg;

endmodule

// File: src/slpl_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted linked priority list: controller
// Head and tail pointers, list walk and read-modify-write of the node pool.
// ----------------------------------------------------------------------------
`include "sorted_linked_priority_list_top_macros.svh"

module slpl_ctrl #(
    parameter int NODES    = 256,
    parameter int KEY_BITS = 32,
    parameter int PW       = 9,
    parameter int IW       = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 in_kind,
    input  logic [7:0]                 in_node_index,
    input  logic signed [KEY_BITS-1:0] in_key,
    output logic                       res_valid,
    input  logic                       res_ready,
    output slpl_pkg::res_t             res,
    output slpl_pkg::mem_we_t          we,
    output logic [IW-1:0]              link_waddr,
    output logic [PW-1:0]              link_wdata,
    output logic [IW-1:0]              key_waddr,
    output logic signed [KEY_BITS-1:0] key_wdata,
    output logic [IW-1:0]              rd_addr,
    input  logic [PW-1:0]              rd_link,
    input  logic signed [KEY_BITS-1:0] rd_key
);
    import slpl_pkg::*;

    localparam logic [PW-1:0] NIL_P   = PW'(NODES);
    localparam logic [16:0]   NODES_V = 17'(NODES);

    state_t                     state_reg, state_next;
    mode_t                      mode_reg, mode_next;
    logic [PW-1:0]              head_reg, head_next;
    logic [PW-1:0]              tail_reg, tail_next;
    logic [PW-1:0]              n_reg, n_next;
    logic signed [KEY_BITS-1:0] k_reg, k_next;
    logic                       empty_reg, empty_next;
    logic [PW-1:0]              cur_reg, cur_next;
    logic [PW-1:0]              prev_reg, prev_next;
    logic [PW-1:0]              steps_reg, steps_next;
    res_t                       res_reg, res_next;

    logic head_nil;
    logic idx_ok;

    assign head_nil = (head_reg == NIL_P);
    assign idx_ok   = ({9'b0, in_node_index} < NODES_V);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= NIL_P;
            tail_reg  <= NIL_P;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        n_reg     <= n_next;
        k_reg     <= k_next;
        empty_reg <= empty_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
        res_reg   <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        empty_next = empty_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        steps_next = steps_reg;
        res_next   = res_reg;
        in_ready   = (state_reg == S_IDLE);
        res_valid  = (state_reg == S_RESP);
        we         = '0;
        link_waddr = n_reg[IW-1:0];
        link_wdata = NIL_P;
        key_waddr  = n_reg[IW-1:0];
        key_wdata  = k_reg;
        rd_addr    = head_reg[IW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    n_next     = PW'(in_node_index);
                    k_next     = in_key;
                    empty_next = head_nil;
                    res_next   = '0;
                    case (in_kind)
                        KIND_POP: begin
                            if (head_nil) begin
                                res_next.status = 1'b1;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_POP;
                            end
                        end
                        KIND_SORTED: begin
                            if (!idx_ok) begin
                                state_next = S_RESP;
                            end else if (head_nil) begin
                                mode_next  = MODE_FRONT;
                                state_next = S_LINK1;
                            end else begin
                                state_next = S_HKEY;
                            end
                        end
                        KIND_PUSH_BACK: begin
                            mode_next  = MODE_BACK;
                            state_next = idx_ok ? S_LINK1 : S_RESP;
                        end
                        KIND_PUSH_FRONT: begin
                            mode_next  = MODE_FRONT;
                            state_next = idx_ok ? S_LINK1 : S_RESP;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP: begin
                res_next.popped_index = 8'(head_reg);
                if (rd_link >= NIL_P) begin
                    head_next = NIL_P;
                    tail_next = NIL_P;
                end else begin
                    head_next = rd_link;
                end
                state_next = S_RESP;
            end
            S_HKEY: begin
                if (k_reg >= rd_key) begin
                    mode_next  = MODE_FRONT;
                    state_next = S_LINK1;
                end else begin
                    rd_addr    = tail_reg[IW-1:0];
                    state_next = S_TKEY;
                end
            end
            S_TKEY: begin
                if (k_reg <= rd_key) begin
                    mode_next  = MODE_BACK;
                    state_next = S_LINK1;
                end else begin
                    cur_next   = head_reg;
                    prev_next  = head_reg;
                    steps_next = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                // one node per cycle: the link just read addresses the next read
                if (steps_reg < NIL_P && rd_link != NIL_P && k_reg <= rd_key) begin
                    prev_next  = cur_reg;
                    cur_next   = rd_link;
                    steps_next = steps_reg + 1'b1;
                    rd_addr    = rd_link[IW-1:0];
                end else begin
                    mode_next  = MODE_MID;
                    state_next = S_LINK1;
                end
            end
            S_LINK1: begin
                we.key_we  = 1'b1;
                we.link_we = 1'b1;
                case (mode_reg)
                    MODE_FRONT: begin
                        link_wdata = empty_reg ? NIL_P : head_reg;
                        head_next  = n_reg;
                        if (empty_reg) begin
                            tail_next = n_reg;
                        end
                        state_next = S_RESP;
                    end
                    MODE_BACK: begin
                        if (empty_reg) begin
                            head_next  = n_reg;
                            tail_next  = n_reg;
                            state_next = S_RESP;
                        end else begin
                            state_next = S_LINK2;
                        end
                    end
                    MODE_MID: begin
                        link_waddr = prev_reg[IW-1:0];
                        link_wdata = n_reg;
                        state_next = S_LINK2;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_LINK2: begin
                we.link_we = 1'b1;
                if (mode_reg == MODE_BACK) begin
                    link_waddr = tail_reg[IW-1:0];
                    link_wdata = n_reg;
                    tail_next  = n_reg;
                end else begin
                    link_wdata = cur_reg;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    `SLPL_ASSERT_NOW(a_head_tail_nil, 1'b1, (head_reg == NIL_P) == (tail_reg == NIL_P), "head and tail disagree on empty list")
    `SLPL_ASSERT_NOW(a_walk_bound, state_reg == S_WALK, steps_reg <= NIL_P, "walk ran past pool size")
    `SLPL_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != S_IDLE, "accepted item not started")
    `SLPL_ASSERT_NXT(a_pop_done, state_reg == S_POP, state_reg == S_RESP && !res_reg.status, "pop of non-empty list flagged empty")

endmodule

// File: src/sorted_linked_priority_list_top.sv
// ----------------------------------------------------------------------------
// Sorted linked priority list: top level
// A singly linked list in a node pool with push front, push back, sorted
// insert (descending) and pop front; one result per item.
// ----------------------------------------------------------------------------
// One item is handled at a time. A sorted insert on a non-empty list first
// compares the key with the head key, then with the tail key, and walks
// the list only when the key lands in between; the walk advances at most
// NODES times. The walk is paced by the node pool's single registered read
// port: each link read addresses the next. The result sits in an output
// register, so the controller is ready for the next item once the previous
// result has moved there, while that result still waits. The pool needs no
// clearing after reset.

module sorted_linked_priority_list_top #(
    parameter int NODES    = 256,
    parameter int KEY_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // node_index [7:0], key [39:8]
    input  logic [1:0]  s_tuser,   // kind [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // popped_index [7:0]
    output logic [0:0]  m_tuser    // status [0]
);
    import slpl_pkg::*;

    localparam int PW = $clog2(NODES + 1);
    localparam int IW = $clog2(NODES);
    localparam logic signed [63:0] KMAX = (64'sd1 <<< (KEY_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] KMIN = -KMAX - 64'sd1;

    logic signed [31:0]         in_key_raw;
    logic signed [63:0]         key_wide;
    logic signed [63:0]         key_clamped;
    logic signed [KEY_BITS-1:0] key_in;

    logic    res_valid;
    logic    res_ready;
    res_t    res;
    mem_we_t we;

    logic [IW-1:0]              link_waddr;
    logic [PW-1:0]              link_wdata;
    logic [IW-1:0]              key_waddr;
    logic signed [KEY_BITS-1:0] key_wdata;
    logic [IW-1:0]              rd_addr;
    logic [PW-1:0]              rd_link;
    logic signed [KEY_BITS-1:0] rd_key;

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;

    // sign-extend, then saturate to the key width
    assign in_key_raw = s_tdata[39:8];
    assign key_wide   = 64'(in_key_raw);

    always_comb begin
        if (key_wide > KMAX) begin
            key_clamped = KMAX;
        end else if (key_wide < KMIN) begin
            key_clamped = KMIN;
        end else begin
            key_clamped = key_wide;
        end
    end

    assign key_in = KEY_BITS'(key_clamped);

    slpl_ctrl #(
        .NODES    (NODES),
        .KEY_BITS (KEY_BITS),
        .PW       (PW),
        .IW       (IW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_kind       (s_tuser),
        .in_node_index (s_tdata[7:0]),
        .in_key        (key_in),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .we            (we),
        .link_waddr    (link_waddr),
        .link_wdata    (link_wdata),
        .key_waddr     (key_waddr),
        .key_wdata     (key_wdata),
        .rd_addr       (rd_addr),
        .rd_link       (rd_link),
        .rd_key        (rd_key)
    );

    slpl_node_mem #(
        .NODES    (NODES),
        .KEY_BITS (KEY_BITS),
        .PW       (PW),
        .IW       (IW)
    ) u_node_mem (
        .aclk       (aclk),
        .we         (we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .key_waddr  (key_waddr),
        .key_wdata  (key_wdata),
        .rd_addr    (rd_addr),
        .rd_link    (rd_link),
        .rd_key     (rd_key)
    );

    // output register
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.popped_index;
    assign m_tuser  = out_res_reg.status;

endmodule
